/* sv/cwed_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes and control types of the cw channel envelope demodulator
package cwed_pkg;

	// quarter-wave sine resolution, a power of two
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
	localparam int X_SHIFT          = 16 - SINE_IDX_BITS;

	// input sample width and its rescale to q1.15
	localparam int SAMPLE_BITS = 16;
	localparam int SAMPLE_UP   = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
	localparam int SAMPLE_DOWN = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;

	// sequencer lengths
	localparam int MUL_STEPS  = 22;
	localparam int SQRT_STEPS = 32;
	localparam int STEP_BITS  = 5;

	// configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	// register reset values
	localparam logic [31:0] PHASE_STEP_RST   = 32'd0;
	localparam logic [15:0] LPF_ALPHA_RST    = 16'd847;
	localparam logic [11:0] DECIM_FACTOR_RST = 12'd240;

	// sine polynomial coefficients in q16
	localparam logic [16:0] POLY_C3 = 17'd307;
	localparam logic [16:0] POLY_C2 = 17'd5223;
	localparam logic [16:0] POLY_C1 = 17'd42334;
	localparam logic [16:0] POLY_C0 = 17'd102944;

	// q16 to q1.15 scale and rounding
	localparam logic [16:0] Q15_SCALE = 17'd32767;
	localparam logic [33:0] Q15_ROUND = 34'd32768;
	localparam logic [15:0] Q15_MAX   = 16'd32767;

	// envelope smoother factor, about 0.3 in q0.16
	localparam logic [15:0] SMOOTH_FACTOR = 16'd19661;

	// phase offset of the cosine
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_PHASE_STEP   = 2'd0,
		CFG_LPF_ALPHA    = 2'd1,
		CFG_DECIM_FACTOR = 2'd2
	} cfg_reg_t;

	// operations of the shared multiplier, suffix s is sine, c cosine,
	// i and q the in-phase and quadrature paths
	typedef enum logic [4:0] {
		OP_NONE,
		OP_X2_S, OP_X2_C,
		OP_P1_S, OP_P1_C,
		OP_P2_S, OP_P2_C,
		OP_P3_S, OP_P3_C,
		OP_R_S, OP_R_C,
		OP_K_S, OP_K_C,
		OP_MIX_Q, OP_MIX_I,
		OP_LPF_Q, OP_LPF_I,
		OP_SQ_QHH, OP_SQ_QHL, OP_SQ_QLL,
		OP_SQ_IHH, OP_SQ_IHL, OP_SQ_ILL,
		OP_SMOOTH
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DRAIN,
		ST_SQRT_LD,
		ST_SQRT,
		ST_EDIFF,
		ST_SMOOTH,
		ST_SMOOTH_WB,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic    load;
		logic    prep;
		mul_op_t mul_op;
		logic    sqrt_load;
		logic    sqrt_step;
		logic    ediff;
		logic    finish;
	} dp_cmd_t;

	typedef struct packed {
		logic emit_due;
		logic out_free;
	} dp_status_t;

	// multiply schedule, sine and cosine chains interleaved so each
	// product is written back before its consumer issues
	function automatic mul_op_t mul_seq(input logic [STEP_BITS-1:0] idx);
		mul_op_t op;
		case (idx)
			5'd0:    op = OP_X2_S;
			5'd1:    op = OP_X2_C;
			5'd2:    op = OP_P1_S;
			5'd3:    op = OP_P1_C;
			5'd4:    op = OP_P2_S;
			5'd5:    op = OP_P2_C;
			5'd6:    op = OP_P3_S;
			5'd7:    op = OP_P3_C;
			5'd8:    op = OP_R_S;
			5'd9:    op = OP_R_C;
			5'd10:   op = OP_K_S;
			5'd11:   op = OP_K_C;
			5'd12:   op = OP_MIX_Q;
			5'd13:   op = OP_MIX_I;
			5'd14:   op = OP_LPF_Q;
			5'd15:   op = OP_LPF_I;
			5'd16:   op = OP_SQ_QHH;
			5'd17:   op = OP_SQ_QHL;
			5'd18:   op = OP_SQ_QLL;
			5'd19:   op = OP_SQ_IHH;
			5'd20:   op = OP_SQ_IHL;
			5'd21:   op = OP_SQ_ILL;
			default: op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

/* sv/cw_channel_envelope_demodulator.sv */
`timescale 1ns / 1ps
// top level of the cw channel envelope demodulator
//
// Input channel (in_valid/in_ready): one word per audio sample, a signed
// q1.15 sample and a restart flag that clears the nco phase, both iir
// filters and the envelope smoother before the sample is used.
// Output channel (out_valid/out_ready): one envelope word, q0.16 and
// saturated, every decim_factor input samples, or every sample when it is zero.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// phase_step, 1 lpf_alpha, 2 decim_factor; other indexes are ignored.
// Write it only while no sample is in flight. cfg_ready is always high.
// Timing: a sample runs through the 22-slot schedule of the single shared
// multiplier and the 32-step square root, and a new sample is taken only
// after the last one is finished. An envelope word is registered as its
// sample finishes.
// Stall: the output word sits in a register; the next sample is taken and
// processed while it waits, and only the next emission waits for it.
// Reset: registers go to their defaults and all filter state to zero.
module cw_channel_envelope_demodulator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [cwed_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                    restart,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [15:0]                             envelope,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [cwed_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [cwed_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	cwed_pkg::dp_cmd_t    cmd;
	cwed_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	// control
	cwed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	cwed_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.envelope  (envelope),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

/* sv/cwed_sqrt.sv */
`timescale 1ns / 1ps
// digit-by-digit integer square root, two radicand bits per step
module cwed_sqrt (
	input  logic        clk,
	input  logic        load,
	input  logic        step,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        fits;

	// bring down the next bit pair and try root*4+1
	assign rem_sh = {rem_q, rad_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	// one root bit per step
	always_ff @(posedge clk) begin
		if (load) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= fits ? 34'(rem_sh - trial) : rem_sh[33:0];
			root_q <= {root_q[30:0], fits};
		end
	end

	assign root = root_q;

endmodule

/* sv/cwed_dp.sv */
`timescale 1ns / 1ps
// datapath: nco, shared multiplier, iir filters, magnitude, smoother, decimation
module cwed_dp (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_valid,
	input  logic [cwed_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [cwed_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	input  logic signed [cwed_pkg::SAMPLE_BITS-1:0]  sample,
	input  logic                                     restart,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [15:0]                              envelope,
	input  cwed_pkg::dp_cmd_t                        cmd,
	output cwed_pkg::dp_status_t                     status
);

	// configuration registers
	logic [31:0] phase_step_q;
	logic [15:0] lpf_alpha_q;
	logic [11:0] decim_factor_q;

	// block state
	logic [31:0]        nco_phase_q;
	logic signed [31:0] filt_i_q;
	logic signed [31:0] filt_qu_q;
	logic [31:0]        env_q;
	logic [11:0]        decim_count_q;

	// working registers
	logic signed [15:0] sample_q;
	logic [16:0]        x_s_q, x_c_q;
	logic [16:0]        x2_s_q, x2_c_q;
	logic [16:0]        p_s_q, p_c_q;
	logic               neg_s_q, neg_c_q;
	logic signed [15:0] trig_s_q, trig_c_q;
	logic signed [32:0] diff_i_q, diff_qu_q;
	logic [63:0]        acc_q;
	logic signed [32:0] ediff_q;

	// multiplier stage
	logic signed [33:0]  mul_a;
	logic signed [17:0]  mul_b;
	logic signed [51:0]  prod_s1;
	cwed_pkg::mul_op_t   op_s1;

	// output register
	logic        out_valid_q;
	logic [15:0] envelope_q;

	// writeback helpers
	logic [16:0]        poly_t;
	logic [33:0]        k_round;
	logic [17:0]        k_t;
	logic [15:0]        k_sat;
	logic signed [15:0] k_trig;
	logic signed [32:0] mix_sh;
	logic [31:0]        lpf_add;

	// sqrt and decimation
	logic [31:0] root;
	logic [31:0] cos_phase;
	logic [11:0] count_next;
	logic        emit_due;
	logic [15:0] env_sat;

	// q1.15 rescale of the input sample
	function automatic logic signed [15:0] to_q15(
		input logic signed [cwed_pkg::SAMPLE_BITS-1:0] s
	);
		logic signed [cwed_pkg::SAMPLE_BITS+15:0] w;
		w = (cwed_pkg::SAMPLE_BITS + 16)'(s);
		w = w <<< cwed_pkg::SAMPLE_UP;
		w = w >>> cwed_pkg::SAMPLE_DOWN;
		return 16'(w);
	endfunction

	// quarter-wave abscissa in q16, mirrored in odd quadrants
	function automatic logic [16:0] quarter_x(input logic [31:0] ph);
		logic [cwed_pkg::SINE_IDX_BITS:0] k;
		k = {1'b0, ph[29 -: cwed_pkg::SINE_IDX_BITS]};
		if (ph[30]) begin
			k = (cwed_pkg::SINE_IDX_BITS + 1)'(cwed_pkg::SINE_TABLE_DEPTH) - k;
		end
		return 17'(k) << cwed_pkg::X_SHIFT;
	endfunction

	cwed_sqrt u_sqrt (
		.clk      (clk),
		.load     (cmd.sqrt_load),
		.step     (cmd.sqrt_step),
		.radicand (acc_q),
		.root     (root)
	);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			cwed_pkg::OP_X2_S: begin
				mul_a = 34'(x_s_q);
				mul_b = 18'(x_s_q);
			end
			cwed_pkg::OP_X2_C: begin
				mul_a = 34'(x_c_q);
				mul_b = 18'(x_c_q);
			end
			cwed_pkg::OP_P1_S: begin
				mul_a = 34'(x2_s_q);
				mul_b = 18'(cwed_pkg::POLY_C3);
			end
			cwed_pkg::OP_P1_C: begin
				mul_a = 34'(x2_c_q);
				mul_b = 18'(cwed_pkg::POLY_C3);
			end
			cwed_pkg::OP_P2_S, cwed_pkg::OP_P3_S: begin
				mul_a = 34'(x2_s_q);
				mul_b = 18'(p_s_q);
			end
			cwed_pkg::OP_P2_C, cwed_pkg::OP_P3_C: begin
				mul_a = 34'(x2_c_q);
				mul_b = 18'(p_c_q);
			end
			cwed_pkg::OP_R_S: begin
				mul_a = 34'(x_s_q);
				mul_b = 18'(p_s_q);
			end
			cwed_pkg::OP_R_C: begin
				mul_a = 34'(x_c_q);
				mul_b = 18'(p_c_q);
			end
			cwed_pkg::OP_K_S: begin
				mul_a = 34'(p_s_q);
				mul_b = 18'(cwed_pkg::Q15_SCALE);
			end
			cwed_pkg::OP_K_C: begin
				mul_a = 34'(p_c_q);
				mul_b = 18'(cwed_pkg::Q15_SCALE);
			end
			cwed_pkg::OP_MIX_Q: begin
				mul_a = 34'(sample_q);
				mul_b = 18'(trig_s_q);
			end
			cwed_pkg::OP_MIX_I: begin
				mul_a = 34'(sample_q);
				mul_b = 18'(trig_c_q);
			end
			cwed_pkg::OP_LPF_Q: begin
				mul_a = 34'(diff_qu_q);
				mul_b = 18'(lpf_alpha_q);
			end
			cwed_pkg::OP_LPF_I: begin
				mul_a = 34'(diff_i_q);
				mul_b = 18'(lpf_alpha_q);
			end
			cwed_pkg::OP_SQ_QHH: begin
				mul_a = 34'($signed(filt_qu_q[31:16]));
				mul_b = 18'($signed(filt_qu_q[31:16]));
			end
			cwed_pkg::OP_SQ_QHL: begin
				mul_a = 34'($signed(filt_qu_q[31:16]));
				mul_b = 18'(filt_qu_q[15:0]);
			end
			cwed_pkg::OP_SQ_QLL: begin
				mul_a = 34'(filt_qu_q[15:0]);
				mul_b = 18'(filt_qu_q[15:0]);
			end
			cwed_pkg::OP_SQ_IHH: begin
				mul_a = 34'($signed(filt_i_q[31:16]));
				mul_b = 18'($signed(filt_i_q[31:16]));
			end
			cwed_pkg::OP_SQ_IHL: begin
				mul_a = 34'($signed(filt_i_q[31:16]));
				mul_b = 18'(filt_i_q[15:0]);
			end
			cwed_pkg::OP_SQ_ILL: begin
				mul_a = 34'(filt_i_q[15:0]);
				mul_b = 18'(filt_i_q[15:0]);
			end
			cwed_pkg::OP_SMOOTH: begin
				mul_a = 34'(ediff_q);
				mul_b = 18'(cwed_pkg::SMOOTH_FACTOR);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product register, tagged with its operation for writeback
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= cwed_pkg::OP_NONE;
		end else begin
			op_s1 <= cmd.mul_op;
		end
	end

	// writeback arithmetic on the registered product
	always_comb begin
		poly_t  = prod_s1[32:16];
		k_round = prod_s1[33:0] + cwed_pkg::Q15_ROUND;
		k_t     = k_round[33:16];
		k_sat   = (k_t > 18'(cwed_pkg::Q15_MAX)) ? cwed_pkg::Q15_MAX : k_t[15:0];
		k_trig  = (op_s1 == cwed_pkg::OP_K_S) ?
			(neg_s_q ? -$signed(k_sat) : $signed(k_sat)) :
			(neg_c_q ? -$signed(k_sat) : $signed(k_sat));
		mix_sh  = $signed({prod_s1[31:15], 16'd0});
		lpf_add = prod_s1[47:16];
	end

	// decimation and output saturation
	assign cos_phase  = nco_phase_q + cwed_pkg::QUARTER_TURN;
	assign count_next = decim_count_q + 12'd1;
	assign emit_due   = (count_next >= decim_factor_q);
	assign env_sat    = (|env_q[31:24]) ? 16'hFFFF : env_q[23:8];

	// working registers without reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= to_q15(sample);
		end
		if (cmd.prep) begin
			x_s_q   <= quarter_x(nco_phase_q);
			x_c_q   <= quarter_x(cos_phase);
			neg_s_q <= nco_phase_q[31];
			neg_c_q <= cos_phase[31];
		end
		if (cmd.ediff) begin
			ediff_q <= $signed({8'd0, root[31:7]}) - $signed({1'b0, env_q});
		end
		case (op_s1)
			cwed_pkg::OP_X2_S:   x2_s_q <= poly_t;
			cwed_pkg::OP_X2_C:   x2_c_q <= poly_t;
			cwed_pkg::OP_P1_S:   p_s_q <= cwed_pkg::POLY_C2 - poly_t;
			cwed_pkg::OP_P1_C:   p_c_q <= cwed_pkg::POLY_C2 - poly_t;
			cwed_pkg::OP_P2_S:   p_s_q <= cwed_pkg::POLY_C1 - poly_t;
			cwed_pkg::OP_P2_C:   p_c_q <= cwed_pkg::POLY_C1 - poly_t;
			cwed_pkg::OP_P3_S:   p_s_q <= cwed_pkg::POLY_C0 - poly_t;
			cwed_pkg::OP_P3_C:   p_c_q <= cwed_pkg::POLY_C0 - poly_t;
			cwed_pkg::OP_R_S:    p_s_q <= poly_t;
			cwed_pkg::OP_R_C:    p_c_q <= poly_t;
			cwed_pkg::OP_K_S:    trig_s_q <= k_trig;
			cwed_pkg::OP_K_C:    trig_c_q <= k_trig;
			cwed_pkg::OP_MIX_Q:  diff_qu_q <= mix_sh - 33'(filt_qu_q);
			cwed_pkg::OP_MIX_I:  diff_i_q <= mix_sh - 33'(filt_i_q);
			cwed_pkg::OP_SQ_QHH: acc_q <= {prod_s1[31:0], 32'd0};
			cwed_pkg::OP_SQ_IHH: acc_q <= acc_q + {prod_s1[31:0], 32'd0};
			cwed_pkg::OP_SQ_QHL, cwed_pkg::OP_SQ_IHL: begin
				acc_q <= acc_q + (64'(prod_s1) << 17);
			end
			cwed_pkg::OP_SQ_QLL, cwed_pkg::OP_SQ_ILL: begin
				acc_q <= acc_q + 64'(prod_s1);
			end
			default: begin
			end
		endcase
		if (cmd.finish && emit_due) begin
			envelope_q <= env_sat;
		end
	end

	// configuration, block state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= cwed_pkg::PHASE_STEP_RST;
			lpf_alpha_q    <= cwed_pkg::LPF_ALPHA_RST;
			decim_factor_q <= cwed_pkg::DECIM_FACTOR_RST;
			nco_phase_q    <= '0;
			filt_i_q       <= '0;
			filt_qu_q      <= '0;
			env_q          <= '0;
			decim_count_q  <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cwed_pkg::cfg_reg_t'(cfg_index))
					cwed_pkg::CFG_PHASE_STEP:   phase_step_q <= cfg_data;
					cwed_pkg::CFG_LPF_ALPHA:    lpf_alpha_q <= cfg_data[15:0];
					cwed_pkg::CFG_DECIM_FACTOR: decim_factor_q <= cfg_data[11:0];
					default: begin
					end
				endcase
			end
			// restart clears phase, filters and smoother, not the decimator
			if (cmd.load && restart) begin
				nco_phase_q <= '0;
				filt_i_q    <= '0;
				filt_qu_q   <= '0;
				env_q       <= '0;
			end
			if (cmd.prep) begin
				nco_phase_q <= nco_phase_q + phase_step_q;
			end
			case (op_s1)
				cwed_pkg::OP_LPF_Q:  filt_qu_q <= filt_qu_q + $signed(lpf_add);
				cwed_pkg::OP_LPF_I:  filt_i_q <= filt_i_q + $signed(lpf_add);
				cwed_pkg::OP_SMOOTH: env_q <= env_q + lpf_add;
				default: begin
				end
			endcase
			if (cmd.finish) begin
				decim_count_q <= emit_due ? 12'd0 : count_next;
			end
			if (cmd.finish && emit_due) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign envelope        = envelope_q;
	assign status.emit_due = emit_due;
	assign status.out_free = !out_valid_q || out_ready;

	// an emitted word never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && emit_due) |-> (!out_valid_q || out_ready))
		else $error("envelope word overwritten while waiting");

	// restart leaves the decimation count alone
	a_restart_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !cmd.finish) |=> $stable(decim_count_q))
		else $error("decimation count changed on sample load");

	// the smoother only moves on its own writeback or a restart
	a_env_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(op_s1 != cwed_pkg::OP_SMOOTH && !cmd.load) |=> $stable(env_q))
		else $error("smoother state changed outside its writeback");

endmodule

/* sv/cwed_ctrl.sv */
`timescale 1ns / 1ps
// controller: sequences load, nco, multiplier schedule, square root and emit
module cwed_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cwed_pkg::dp_status_t status,
	output cwed_pkg::dp_cmd_t    cmd
);

	localparam logic [cwed_pkg::STEP_BITS-1:0] MUL_LAST =
		cwed_pkg::STEP_BITS'(cwed_pkg::MUL_STEPS - 1);
	localparam logic [cwed_pkg::STEP_BITS-1:0] SQRT_LAST =
		cwed_pkg::STEP_BITS'(cwed_pkg::SQRT_STEPS - 1);

	cwed_pkg::state_t                state_q, state_d;
	logic [cwed_pkg::STEP_BITS-1:0]  step_q, step_d;
	logic                            finish_ok;

	assign finish_ok = !status.emit_due || status.out_free;

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cwed_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			cwed_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = cwed_pkg::ST_PREP;
				end
			end
			cwed_pkg::ST_PREP: begin
				state_d = cwed_pkg::ST_MUL;
				step_d  = '0;
			end
			cwed_pkg::ST_MUL: begin
				step_d = step_q + 1'b1;
				if (step_q == MUL_LAST) begin
					state_d = cwed_pkg::ST_DRAIN;
				end
			end
			cwed_pkg::ST_DRAIN: begin
				state_d = cwed_pkg::ST_SQRT_LD;
			end
			cwed_pkg::ST_SQRT_LD: begin
				state_d = cwed_pkg::ST_SQRT;
				step_d  = '0;
			end
			cwed_pkg::ST_SQRT: begin
				step_d = step_q + 1'b1;
				if (step_q == SQRT_LAST) begin
					state_d = cwed_pkg::ST_EDIFF;
				end
			end
			cwed_pkg::ST_EDIFF: begin
				state_d = cwed_pkg::ST_SMOOTH;
			end
			cwed_pkg::ST_SMOOTH: begin
				state_d = cwed_pkg::ST_SMOOTH_WB;
			end
			cwed_pkg::ST_SMOOTH_WB: begin
				state_d = cwed_pkg::ST_FINISH;
			end
			cwed_pkg::ST_FINISH: begin
				if (finish_ok) begin
					state_d = cwed_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cwed_pkg::ST_IDLE;
			end
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd        = '0;
		cmd.mul_op = cwed_pkg::OP_NONE;
		in_ready   = 1'b0;
		case (state_q)
			cwed_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			cwed_pkg::ST_PREP:   cmd.prep = 1'b1;
			cwed_pkg::ST_MUL:    cmd.mul_op = cwed_pkg::mul_seq(step_q);
			cwed_pkg::ST_SQRT_LD: cmd.sqrt_load = 1'b1;
			cwed_pkg::ST_SQRT:   cmd.sqrt_step = 1'b1;
			cwed_pkg::ST_EDIFF:  cmd.ediff = 1'b1;
			cwed_pkg::ST_SMOOTH: cmd.mul_op = cwed_pkg::OP_SMOOTH;
			cwed_pkg::ST_FINISH: cmd.finish = finish_ok;
			default: begin
			end
		endcase
	end

	// a taken sample keeps the input closed until it is finished
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input reopened right after a sample was taken");

	// the root iterations follow the radicand load directly
	a_sqrt_follows_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_load |=> cmd.sqrt_step)
		else $error("square root not stepped after load");

	// the multiplier is quiet while the root iterates
	a_no_mul_in_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_step |-> (cmd.mul_op == cwed_pkg::OP_NONE))
		else $error("multiplier issued during square root");

	// finishing a sample opens the input again
	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> in_ready)
		else $error("input not reopened after finish");

endmodule

/* tb/cwed_envelope_checker.sv */
`timescale 1ns / 1ps
// envelope predictor and scoreboard watching the demodulator channels
module cwed_envelope_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic signed [cwed_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                    restart,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic [15:0]                             envelope,
	input  logic                                    cfg_valid,
	input  logic                                    cfg_ready,
	input  logic [cwed_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [cwed_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	output int                                      mismatches,
	output int                                      outstanding
);
	import cwed_pkg::*;

	// register copies
	logic [31:0] step_cfg;
	logic [15:0] alpha_cfg;
	logic [11:0] decim_cfg;

	// demodulator state
	logic [31:0]        phase_acc;
	logic signed [31:0] acc_i;
	logic signed [31:0] acc_q;
	logic [31:0]        env_acc;
	logic [11:0]        since_emit;

	logic [15:0] envelope_due[$];
	logic [15:0] want;
	int          fail_count = 0;

	// quarter-wave sine at table index k, q1.15
	function automatic longint quarter_wave_sine(input longint unsigned k);
		longint unsigned x, x2, p, r;
		x  = (k << 16) / 64'(SINE_TABLE_DEPTH);
		x2 = (x * x) >> 16;
		p  = 64'd5223 - ((x2 * 64'd307) >> 16);
		p  = 64'd42334 - ((x2 * p) >> 16);
		p  = 64'd102944 - ((x2 * p) >> 16);
		r  = (x * p) >> 16;
		r  = (r * 64'd32767 + 64'd32768) >> 16;
		if (r > 64'd32767)
			r = 64'd32767;
		return longint'(r);
	endfunction

	// full-turn sine from the quadrant and the mirrored table index
	function automatic longint nco_sine(input logic [31:0] phase);
		longint unsigned idx;
		longint          mag;
		idx = ({34'd0, phase[29:0]} * 64'(SINE_TABLE_DEPTH)) >> 30;
		if (phase[30])
			idx = 64'(SINE_TABLE_DEPTH) - idx;
		mag = quarter_wave_sine(idx);
		return phase[31] ? -mag : mag;
	endfunction

	// exact floor square root, bit by bit
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned rem, root, bitv;
		rem  = v;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem  = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// one-pole low-pass, q1.31 state
	function automatic logic signed [31:0] iir_update(input logic signed [31:0] f,
		input longint mix);
		longint diff;
		diff = mix * 64'sd65536 - longint'(f);
		return 32'(longint'(f) + ((longint'(alpha_cfg) * diff) >>> 16));
	endfunction

	// mix, filter, magnitude, smooth, decimate one sample
	task automatic advance_envelope(input logic signed [SAMPLE_BITS-1:0] word,
		input logic clear);
		longint          s, cos_v, sin_v, mix_i, mix_q, mag, ediff;
		longint unsigned pwr;
		logic [31:0]     env_q;
		s = longint'(word);
		s = (s >>> SAMPLE_DOWN) <<< SAMPLE_UP;
		if (clear) begin
			phase_acc = '0;
			acc_i     = '0;
			acc_q     = '0;
			env_acc   = '0;
		end
		cos_v     = nco_sine(phase_acc + QUARTER_TURN);
		sin_v     = nco_sine(phase_acc);
		mix_i     = (s * cos_v) >>> 15;
		mix_q     = (s * sin_v) >>> 15;
		phase_acc = phase_acc + step_cfg;
		acc_i     = iir_update(acc_i, mix_i);
		acc_q     = iir_update(acc_q, mix_q);
		pwr       = $unsigned(longint'(acc_i) * longint'(acc_i)) +
			$unsigned(longint'(acc_q) * longint'(acc_q));
		mag       = longint'(int_sqrt(pwr) >> 7);
		ediff     = mag - longint'(env_acc);
		env_acc   = 32'(longint'(env_acc) + ((ediff * longint'(SMOOTH_FACTOR)) >>> 16));
		since_emit = since_emit + 12'd1;
		if (since_emit >= decim_cfg) begin
			since_emit = '0;
			env_q      = env_acc >> 8;
			envelope_due.push_back((env_q > 32'd65535) ? 16'hFFFF : env_q[15:0]);
		end
	endtask

	// watch the three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cfg   = PHASE_STEP_RST;
			alpha_cfg  = LPF_ALPHA_RST;
			decim_cfg  = DECIM_FACTOR_RST;
			phase_acc  = '0;
			acc_i      = '0;
			acc_q      = '0;
			env_acc    = '0;
			since_emit = '0;
			envelope_due.delete();
			mismatches  <= fail_count;
			outstanding <= 0;
		end else begin
			// envelope word leaving the block
			if (out_valid && out_ready) begin
				if (envelope_due.size() == 0) begin
					$error("envelope: expected none, actual %0d", envelope);
					fail_count++;
				end else begin
					want = envelope_due.pop_front();
					if (want != envelope) begin
						$error("envelope: expected %0d, actual %0d", want, envelope);
						fail_count++;
					end
				end
			end
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PHASE_STEP:   step_cfg = cfg_data;
					CFG_LPF_ALPHA:    alpha_cfg = cfg_data[15:0];
					CFG_DECIM_FACTOR: decim_cfg = cfg_data[11:0];
					default: ;
				endcase
			end
			// sample word entering the block
			if (in_valid && in_ready)
				advance_envelope(sample, restart);
			mismatches  <= fail_count;
			outstanding <= envelope_due.size();
		end
	end

endmodule

/* tb/tb_cw_channel_envelope_demodulator.sv */
`timescale 1ns / 1ps
// testbench top of the cw channel envelope demodulator: stimulus and verdict
module tb_cw_channel_envelope_demodulator;
	import cwed_pkg::*;

	localparam int W             = SAMPLE_BITS;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 80;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_ITEMS   = 53;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	logic signed [W-1:0]          sample    = '0;
	logic                         restart   = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b1;
	logic [15:0]                  envelope;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]     cfg_data  = '0;
	int                           mismatches;
	int                           outstanding;
	logic                         quiet     = 1'b0;
	int unsigned                  hold_left = 0;
	int unsigned                  stuck     = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	cw_channel_envelope_demodulator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.envelope  (envelope),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cwed_envelope_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.envelope    (envelope),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			hold_left <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stuck <= 0;
		end else if (stuck == IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	// one sample word, with a random gap ahead of it
	task automatic put_sample(input logic signed [W-1:0] s, input logic clear);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		restart  <= clear;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// one register word; valid is left high for a following write
	task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_registers(input logic [31:0] step, input logic [15:0] alpha,
		input logic [11:0] decim, input bit spare);
		if (spare)
			put_reg(CFG_SPARE, $urandom());
		put_reg(CFG_PHASE_STEP, step);
		put_reg(CFG_LPF_ALPHA, {16'd0, alpha});
		put_reg(CFG_DECIM_FACTOR, {20'd0, decim});
		cfg_valid <= 1'b0;
	endtask

	// drain every expected word, then let a sample with no result finish
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0 || out_valid);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          mode;
		int          v;
		real         amp;
		real         period;
		bit          keyed_on;
		logic [31:0] step_val;
		logic [15:0] alpha_val;
		logic [11:0] decim_val;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, count carried into the next setting
		put_sample(16'sh7FFF, 1'b0);
		put_sample(-16'sh4000, 1'b0);
		settle();

		// decimation of zero emits every sample, extremes of the sample
		set_registers(32'h0800_0000, 16'hFFFF, 12'd0, 1'b1);
		put_sample(16'sh7FFF, 1'b0);
		put_sample(16'sh8000, 1'b0);
		put_sample(16'sh0000, 1'b0);
		put_sample(-16'sh0001, 1'b0);
		put_sample(16'sh0001, 1'b0);
		put_sample(16'sh5555, 1'b0);
		put_sample(16'shAAAA, 1'b0);
		put_sample(16'sh7FFF, 1'b1);
		put_sample(16'sh7FFF, 1'b0);
		put_sample(16'sh8000, 1'b0);
		settle();

		// largest decimation, then lowered below the running count
		set_registers(32'h0123_4567, 16'd847, 12'd4095, 1'b0);
		put_sample(16'sh8000, 1'b0);
		put_sample(16'sh7FFF, 1'b0);
		put_sample(16'sh04D2, 1'b0);
		settle();

		// phase wraps every sample, frozen filters, restart mid-run
		set_registers(32'hFFFF_FFFF, 16'd0, 12'd2, 1'b1);
		put_sample(16'sh7FFF, 1'b0);
		put_sample(16'sh8000, 1'b0);
		put_sample(16'sh7FFF, 1'b1);
		put_sample(16'sh8000, 1'b0);
		put_sample(16'sh3FFF, 1'b0);
		settle();

		// quarter-turn steps land on the quadrant boundaries
		set_registers(32'h4000_0000, 16'h8000, 12'd1, 1'b0);
		repeat (4) put_sample(16'sh7FFF, 1'b0);
		settle();

		// random phases: tones, keyed tones, noise and extremes
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			quiet <= (ph >= RAND_PHASES - 2) || ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 4))
				0:       step_val = 32'd0;
				1:       step_val = 32'hFFFF_FFFF;
				2:       step_val = $urandom_range(1, 32'h0400_0000);
				default: step_val = $urandom();
			endcase
			case ($urandom_range(0, 5))
				0:       alpha_val = 16'd0;
				1:       alpha_val = 16'hFFFF;
				2:       alpha_val = 16'd847;
				default: alpha_val = 16'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 5))
				0:       decim_val = 12'd0;
				1:       decim_val = 12'd1;
				default: decim_val = 12'($urandom_range(2, 12));
			endcase
			set_registers(step_val, alpha_val, decim_val, $urandom_range(0, 2) == 0);

			mode     = $urandom_range(0, 5);
			amp      = $urandom_range(0, 32767);
			period   = $urandom_range(2, 64);
			keyed_on = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				case (mode)
					0, 1: v = $rtoi(amp * $sin(6.283185307 * k / period));
					2, 3: begin
						// on-off keyed tone
						if ($urandom_range(0, 9) == 0)
							keyed_on = !keyed_on;
						v = keyed_on ? $rtoi(amp * $sin(6.283185307 * k / period)) : 0;
					end
					4: v = int'($urandom());
					default: begin
						case ($urandom_range(0, 3))
							0:       v = 32767;
							1:       v = -32768;
							2:       v = 0;
							default: v = -1;
						endcase
					end
				endcase
				put_sample(W'(v), $urandom_range(0, 31) == 0);
			end
			settle();
		end

		// verdict once nothing is left in flight
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
